// ===== src/bfm3_pkg.sv =====
package bfm3_pkg;

  // Filter size default, handed to the top level parameter
  localparam int unsigned FilterBitsDefault = 32;

  localparam int unsigned NumLanes = 4;

  // Operation codes
  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;

  // MurmurHash3 x86_32 constants
  localparam logic [31:0] MixC1    = 32'hcc9e2d51;
  localparam logic [31:0] MixC2    = 32'h1b873593;
  localparam logic [31:0] MixAdd   = 32'he6546b64;
  localparam logic [31:0] FinMulC3 = 32'h85ebca6b;
  localparam logic [31:0] FinMulC4 = 32'hc2b2ae35;

  // One seed per lane, lane 0 in the low word
  localparam logic [NumLanes-1:0][31:0] LaneSeeds = {
    32'h0000_0678, 32'h0000_0456, 32'h0000_0345, 32'h0000_0234
  };

  // Commands from controller to datapath
  typedef struct packed {
    logic       capture;    // latch the accepted word
    logic       pend_add;   // add byte to partial block, bump length
    logic       blk_mul1;   // k = block * C1
    logic       tail_mul1;  // k = tail bytes * C1
    logic       mul2;       // k = rotl(k,15) * C2
    logic       lane_upd;   // fold full block into all lanes
    logic       tail_xor;   // fold tail into all lanes
    logic       fmix0;      // h ^= len; h ^= h >> 16
    logic       fmix1;      // h *= C3
    logic       fmix2;      // h = (h ^ h >> 13) * C4
    logic       fmix3;      // h ^= h >> 16
    logic       mod_mul;    // quotient estimate from reciprocal
    logic       mod_sub;    // h -= quotient * filter size
    logic       mod_fix;    // final compare and subtract into remainder
    logic       filt_upd;   // set or test one filter bit
    logic       out_load;   // load result, restart key
    logic [1:0] lane;       // lane for filt_upd
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pos3;        // next byte completes a block
    logic tail_nz;     // partial block pending
    logic item_last;   // latched last_byte
  } dp_stat_t;

endpackage

// ===== src/bfm3_ctrl.sv =====
module bfm3_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               byte_valid_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bfm3_pkg::dp_stat_t stat_i,
  output bfm3_pkg::dp_cmd_t  cmd_o
);
  import bfm3_pkg::*;

  localparam logic [4:0] StIdle   = 5'd0;
  localparam logic [4:0] StBMul1  = 5'd1;
  localparam logic [4:0] StBMul2  = 5'd2;
  localparam logic [4:0] StBLane  = 5'd3;
  localparam logic [4:0] StFin    = 5'd4;
  localparam logic [4:0] StTMul1  = 5'd5;
  localparam logic [4:0] StTMul2  = 5'd6;
  localparam logic [4:0] StTXor   = 5'd7;
  localparam logic [4:0] StFmix0  = 5'd8;
  localparam logic [4:0] StFmix1  = 5'd9;
  localparam logic [4:0] StFmix2  = 5'd10;
  localparam logic [4:0] StFmix3  = 5'd11;
  localparam logic [4:0] StModMul = 5'd12;
  localparam logic [4:0] StModSub = 5'd13;
  localparam logic [4:0] StModFix = 5'd14;
  localparam logic [4:0] StUpd    = 5'd15;
  localparam logic [4:0] StOut    = 5'd16;

  logic [4:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture  = 1'b1;
          cmd_o.pend_add = byte_valid_i & ~stat_i.pos3;
          if (byte_valid_i && stat_i.pos3) begin
            state_d = StBMul1;
          end else if (last_byte_i) begin
            state_d = StFin;
          end
        end
      end
      StBMul1: begin
        cmd_o.blk_mul1 = 1'b1;
        state_d = StBMul2;
      end
      StBMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d = StBLane;
      end
      StBLane: begin
        cmd_o.lane_upd = 1'b1;
        state_d = stat_i.item_last ? StFin : StIdle;
      end
      StFin: begin
        state_d = stat_i.tail_nz ? StTMul1 : StFmix0;
      end
      StTMul1: begin
        cmd_o.tail_mul1 = 1'b1;
        state_d = StTMul2;
      end
      StTMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d = StTXor;
      end
      StTXor: begin
        cmd_o.tail_xor = 1'b1;
        state_d = StFmix0;
      end
      StFmix0: begin
        cmd_o.fmix0 = 1'b1;
        state_d = StFmix1;
      end
      StFmix1: begin
        cmd_o.fmix1 = 1'b1;
        state_d = StFmix2;
      end
      StFmix2: begin
        cmd_o.fmix2 = 1'b1;
        state_d = StFmix3;
      end
      StFmix3: begin
        cmd_o.fmix3 = 1'b1;
        cnt_d   = '0;
        state_d = StModMul;
      end
      // Remainder in three steps, all lanes together
      StModMul: begin
        cmd_o.mod_mul = 1'b1;
        state_d = StModSub;
      end
      StModSub: begin
        cmd_o.mod_sub = 1'b1;
        state_d = StModFix;
      end
      StModFix: begin
        cmd_o.mod_fix = 1'b1;
        state_d = StUpd;
      end
      // One lane per cycle against the filter
      StUpd: begin
        cmd_o.filt_upd = 1'b1;
        cmd_o.lane     = cnt_q;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = StOut;
        end
      end
      // Wait for the output register to free up
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Result word held until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/bfm3_dp.sv =====
module bfm3_dp #(
  parameter int unsigned FILTER_BITS = bfm3_pkg::FilterBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               operation_i,
  input  logic [7:0]         key_byte_i,
  input  logic               last_byte_i,
  input  bfm3_pkg::dp_cmd_t  cmd_i,
  output bfm3_pkg::dp_stat_t stat_o,
  output logic               found_o,
  output logic [31:0]        filter_word_o
);
  import bfm3_pkg::*;

  localparam int unsigned Words = (FILTER_BITS + 31) / 32;
  localparam int unsigned WaW   = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned IdxW  = $clog2(FILTER_BITS);
  // floor(2^32 / FILTER_BITS): quotient estimate is low by at most one
  localparam logic [31:0] ModRecip = 32'((64'd1 << 32) / 64'(FILTER_BITS));
  localparam logic [31:0] ModSize  = 32'(FILTER_BITS);

  // Latched input word
  logic        op_q, item_last_q;
  logic [7:0]  byte_q;

  // Key state
  logic [23:0] pend_q, pend_d;
  logic [31:0] len_q, len_d;
  logic [31:0] k_q, k_d;
  logic [NumLanes-1:0][31:0]   h_q, h_d;
  logic [NumLanes-1:0][31:0]   quo_q, quo_d;
  logic [NumLanes-1:0][IdxW-1:0] rem_q, rem_d;
  logic        all_set_q, all_set_d;

  // Filter words and result register
  logic [31:0] filt_q [Words];
  logic [31:0] filt_d [Words];
  logic        found_q, found_d;
  logic [31:0] fword_q, fword_d;

  logic [31:0] mul_a, mul_b, k_rot;
  logic [31:0] upd_idx;
  logic [WaW-1:0] upd_word;
  logic [31:0] upd_mask, upd_rd;

  assign stat_o.pos3       = (len_q[1:0] == 2'd3);
  assign stat_o.tail_nz    = (len_q[1:0] != 2'd0);
  assign stat_o.item_last  = item_last_q;
  assign found_o       = found_q;
  assign filter_word_o = fword_q;

  // Shared scramble multiplier
  assign k_rot = {k_q[16:0], k_q[31:17]};
  always_comb begin
    if (cmd_i.blk_mul1) begin
      mul_a = {byte_q, pend_q};
    end else if (cmd_i.tail_mul1) begin
      mul_a = {8'h00, pend_q};
    end else begin
      mul_a = k_rot;
    end
    mul_b = cmd_i.mul2 ? MixC2 : MixC1;
    k_d   = k_q;
    if (cmd_i.blk_mul1 || cmd_i.tail_mul1 || cmd_i.mul2) begin
      k_d = mul_a * mul_b;
    end
  end

  // Partial block and length
  always_comb begin
    pend_d = pend_q;
    len_d  = len_q;
    if (cmd_i.pend_add) begin
      case (len_q[1:0])
        2'd0:    pend_d[7:0]   = key_byte_i;
        2'd1:    pend_d[15:8]  = key_byte_i;
        2'd2:    pend_d[23:16] = key_byte_i;
        default: pend_d        = pend_q;
      endcase
      len_d = len_q + 32'd1;
    end
    if (cmd_i.lane_upd) begin
      pend_d = '0;
      len_d  = len_q + 32'd1;
    end
    if (cmd_i.out_load) begin
      pend_d = '0;
      len_d  = '0;
    end
  end

  // Hash lanes: block and tail fold, final mix, reciprocal remainder and seed reload
  always_comb begin
    logic [31:0] t, hr, fa, fb;
    logic [63:0] prod;
    h_d   = h_q;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < NumLanes; i++) begin
      t  = h_q[i] ^ k_q;
      hr = {t[18:0], t[31:19]};
      fa = cmd_i.fmix2 ? (h_q[i] ^ (h_q[i] >> 13)) : h_q[i];
      if (cmd_i.fmix2) begin
        fb = FinMulC4;
      end else if (cmd_i.mod_mul) begin
        fb = ModRecip;
      end else begin
        fb = FinMulC3;
      end
      prod = {32'd0, fa} * {32'd0, fb};
      if (cmd_i.lane_upd) begin
        h_d[i] = (hr << 2) + hr + MixAdd;
      end
      if (cmd_i.tail_xor) begin
        h_d[i] = t;
      end
      if (cmd_i.fmix0) begin
        t      = h_q[i] ^ len_q;
        h_d[i] = t ^ (t >> 16);
      end
      if (cmd_i.fmix1 || cmd_i.fmix2) begin
        h_d[i] = prod[31:0];
      end
      if (cmd_i.fmix3) begin
        h_d[i] = h_q[i] ^ (h_q[i] >> 16);
      end
      if (cmd_i.mod_mul) begin
        quo_d[i] = prod[63:32];
      end
      // Leaves a value below twice the filter size
      if (cmd_i.mod_sub) begin
        h_d[i] = h_q[i] - quo_q[i] * ModSize;
      end
      if (cmd_i.mod_fix) begin
        if (h_q[i] >= ModSize) begin
          rem_d[i] = IdxW'(h_q[i] - ModSize);
        end else begin
          rem_d[i] = IdxW'(h_q[i]);
        end
      end
      if (cmd_i.out_load) begin
        h_d[i] = LaneSeeds[i];
      end
    end
  end

  // Filter read-modify-write, one lane a cycle
  assign upd_idx  = 32'(rem_q[cmd_i.lane]);
  assign upd_word = upd_idx[5 +: WaW];
  assign upd_mask = 32'd1 << upd_idx[4:0];
  assign upd_rd   = filt_q[upd_word];

  always_comb begin
    filt_d    = filt_q;
    all_set_d = all_set_q;
    if (cmd_i.fmix3) begin
      all_set_d = 1'b1;
    end
    if (cmd_i.filt_upd) begin
      if (op_q == OpInsert) begin
        filt_d[upd_word] = upd_rd | upd_mask;
      end else if ((upd_rd & upd_mask) == 32'd0) begin
        all_set_d = 1'b0;
      end
    end
  end

  // Result register
  always_comb begin
    found_d = found_q;
    fword_d = fword_q;
    if (cmd_i.out_load) begin
      found_d = (op_q == OpQuery) & all_set_q;
      fword_d = filt_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_last_q  <= 1'b0;
      pend_q       <= '0;
      len_q        <= '0;
      h_q          <= LaneSeeds;
      all_set_q    <= 1'b0;
      for (int w = 0; w < Words; w++) begin
        filt_q[w] <= '0;
      end
    end else begin
      if (cmd_i.capture) begin
        item_last_q  <= last_byte_i;
      end
      pend_q    <= pend_d;
      len_q     <= len_d;
      h_q       <= h_d;
      all_set_q <= all_set_d;
      filt_q    <= filt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      byte_q <= key_byte_i;
    end
    k_q     <= k_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    found_q <= found_d;
    fword_q <= fword_d;
  end

endmodule

// ===== src/bloom_filter_murmur3_32bit.sv =====
// Channel  Handshake              Word
// -------  ---------------------  ------------------------------------------
// input    in_valid_i/in_ready_o  operation_i, key_byte_i, byte_valid_i,
//                                 last_byte_i
// output   out_valid_o/out_ready_i found_o, filter_word_o
//
// A byte that does not complete a 4-byte block joins the partial block; one that
// completes a block runs two dependent scramble multiplies, then the lane fold.
// A last word adds the tail fold if bytes remain, the final mix, a three-step
// reciprocal remainder for all lanes at once and one filter read-modify-write
// per lane. Reset clears the filter and loads the seeds. The result sits in an
// output register; only a following last word stalls on it, in its final cycle.
module bloom_filter_murmur3_32bit #(
  parameter int unsigned FILTER_BITS = bfm3_pkg::FilterBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  key_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [31:0] filter_word_o
);
  import bfm3_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  bfm3_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_valid_i (byte_valid_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // Hash lanes and filter
  bfm3_dp #(
    .FILTER_BITS (FILTER_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (operation_i),
    .key_byte_i    (key_byte_i),
    .last_byte_i   (last_byte_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .found_o       (found_o),
    .filter_word_o (filter_word_o)
  );

endmodule

// ===== tb/sv/bloom_filter_murmur3_32bit_test.sv =====
module bloom_filter_murmur3_32bit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bfm3_pkg::*;

  localparam int unsigned FilterBits  = FilterBitsDefault;
  localparam int unsigned RandomItems = 1550;
  localparam int unsigned CalmTail    = 300;   // last words sent with no idling
  localparam int unsigned StallLimit  = 3000;  // cycles with no word accepted
  localparam int unsigned DrainCycles = 60;

  // One input word and one predicted result
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       valid;
    logic       last;
  } key_word_t;

  typedef struct packed {
    logic        found;
    logic [31:0] bits;
  } probe_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        operation_i = 1'b0;
  logic [7:0]  key_byte_i = 8'h00;
  logic        byte_valid_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        found_o;
  logic [31:0] filter_word_o;

  key_word_t     key_stream_q[$];
  probe_result_t probe_results_q[$];
  int unsigned   mismatches = 0;

  // Predictor state: four running hashes, partial block, length, filter
  logic [31:0] lane_hash[NumLanes];
  logic [23:0] partial_block;
  logic [31:0] key_bytes;
  logic [31:0] filter_bits;

  bloom_filter_murmur3_32bit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .key_byte_i   (key_byte_i),
    .byte_valid_i (byte_valid_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .filter_word_o(filter_word_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_block(input logic [31:0] k);
    logic [31:0] t;
    t = k * MixC1;
    t = rotl32(t, 15);
    return t * MixC2;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * FinMulC3;
    t = t ^ (t >> 13);
    t = t * FinMulC4;
    return t ^ (t >> 16);
  endfunction

  task automatic restart_key();
    for (int i = 0; i < NumLanes; i++) lane_hash[i] = LaneSeeds[i];
    partial_block = '0;
    key_bytes = '0;
  endtask

  // Fold one accepted word into the hashes; on the last word probe the filter
  task automatic hash_and_probe(input key_word_t w);
    logic [31:0] k;
    logic [31:0] h;
    int unsigned idx;
    logic        all_set;
    all_set = 1'b1;
    if (w.valid) begin
      if (key_bytes[1:0] == 2'd3) begin
        k = mix_block({w.data, partial_block});
        for (int i = 0; i < NumLanes; i++) begin
          h = rotl32(lane_hash[i] ^ k, 13);
          lane_hash[i] = h * 32'd5 + MixAdd;
        end
        partial_block = '0;
      end else begin
        partial_block = partial_block | (24'(w.data) << (8 * key_bytes[1:0]));
      end
      key_bytes = key_bytes + 32'd1;
    end
    if (w.last) begin
      for (int i = 0; i < NumLanes; i++) begin
        h = lane_hash[i];
        if (key_bytes[1:0] != 2'd0) h = h ^ mix_block({8'h00, partial_block});
        h = avalanche(h ^ key_bytes);
        idx = h % FilterBits;
        if (w.op == OpInsert) filter_bits[idx[4:0]] = 1'b1;
        else if (!filter_bits[idx[4:0]]) all_set = 1'b0;
      end
      probe_results_q.push_back('{found: (w.op == OpQuery) && all_set, bits: filter_bits});
      restart_key();
    end
  endtask

  function automatic void queue_word(input logic op, input logic [7:0] data,
                                     input logic valid, input logic last);
    key_stream_q.push_back('{op: op, data: data, valid: valid, last: last});
  endfunction

  // Stimulus and end of run
  initial begin
    int unsigned sent;
    int unsigned len;
    logic        op;
    logic        end_empty;
    restart_key();
    filter_bits = '0;

    // Empty keys, before and after inserting one
    queue_word(OpInsert, 8'h00, 1'b0, 1'b1);
    queue_word(OpQuery,  8'h00, 1'b0, 1'b1);
    // Idle word carrying junk, then one-byte keys at the byte extremes
    queue_word(OpQuery,  8'h5a, 1'b0, 1'b0);
    queue_word(OpInsert, 8'h00, 1'b1, 1'b1);
    queue_word(OpQuery,  8'hff, 1'b1, 1'b1);
    // Exactly one block; early operation codes are ignored
    queue_word(OpInsert, 8'hff, 1'b1, 1'b0);
    queue_word(OpInsert, 8'h00, 1'b1, 1'b0);
    queue_word(OpInsert, 8'h80, 1'b1, 1'b0);
    queue_word(OpQuery,  8'h7f, 1'b1, 1'b1);
    // Three tail bytes, closed by an empty last word after an idle word
    queue_word(OpQuery,  8'ha5, 1'b1, 1'b0);
    queue_word(OpQuery,  8'h5a, 1'b1, 1'b0);
    queue_word(OpQuery,  8'h01, 1'b1, 1'b0);
    queue_word(OpQuery,  8'h33, 1'b0, 1'b0);
    queue_word(OpInsert, 8'hc3, 1'b0, 1'b1);
    // Block plus one tail byte, inserted then queried
    for (int r = 0; r < 2; r++) begin
      queue_word(OpQuery, 8'h12, 1'b1, 1'b0);
      queue_word(OpQuery, 8'h34, 1'b1, 1'b0);
      queue_word(OpQuery, 8'h56, 1'b1, 1'b0);
      queue_word(OpQuery, 8'h78, 1'b1, 1'b0);
      queue_word(r == 0 ? OpInsert : OpQuery, 8'h9a, 1'b1, 1'b1);
    end

    // Random keys: mostly short, a few long; inserts kept rare so the filter
    // fills slowly and queries keep both outcomes
    sent = 0;
    while (sent < RandomItems) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
      op = ($urandom_range(0, 15) == 0) ? OpInsert : OpQuery;
      end_empty = (len == 0) || ($urandom_range(0, 5) == 0);
      for (int b = 0; b < len; b++) begin
        if ($urandom_range(0, 11) == 0) begin
          queue_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b0);
          sent++;
        end
        if (!end_empty && b == len - 1)
          queue_word(op, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
        else
          queue_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1, 1'b0);
        sent++;
      end
      if (end_empty) begin
        queue_word(op, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
        sent++;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (key_stream_q.size() != 0 || in_valid_i || probe_results_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Driver: present the next word, with random idle bursts
  int unsigned in_gap = 0;
  logic        in_calm_phase = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    key_word_t nxt;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      operation_i  <= 1'b0;
      key_byte_i   <= 8'h00;
      byte_valid_i <= 1'b0;
      last_byte_i  <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o)
        hash_and_probe('{op: operation_i, data: key_byte_i, valid: byte_valid_i,
                         last: last_byte_i});
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (key_stream_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!in_calm_phase && key_stream_q.size() > CalmTail &&
                     $urandom_range(0, 6) == 0) begin
          in_gap = $urandom_range(0, 16);
          in_valid_i <= 1'b0;
        end else begin
          nxt = key_stream_q.pop_front();
          in_valid_i   <= 1'b1;
          operation_i  <= nxt.op;
          key_byte_i   <= nxt.data;
          byte_valid_i <= nxt.valid;
          last_byte_i  <= nxt.last;
          if ($urandom_range(0, 40) == 0) in_calm_phase = !in_calm_phase;
        end
      end
    end
  end

  // Monitor: check each accepted result, stall the output at random
  int unsigned out_stall = 0;
  logic        out_calm_phase = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    probe_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (probe_results_q.size() == 0) begin
          $display("%0t: unexpected result, found %0b filter %h", $time, found_o,
                   filter_word_o);
          mismatches++;
        end else begin
          want = probe_results_q.pop_front();
          if (found_o !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found_o);
            mismatches++;
          end
          if (filter_word_o !== want.bits) begin
            $display("%0t: filter_word expected %h actual %h", $time, want.bits,
                     filter_word_o);
            mismatches++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else if (!out_calm_phase && key_stream_q.size() > CalmTail &&
                   $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(0, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 60) == 0) out_calm_phase = !out_calm_phase;
      end
    end
  end

  // Watchdog on cycles with no word accepted on either side
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
